>>> rtl/etcs_pkg.sv
// Shared types, codes and sizes for the EEPROM transfer chunk splitter.
// No dependencies; every other file imports this package.
package etcs_pkg;

   localparam int MAX_CHUNKS        = 64;
   localparam int MAX_LENGTH        = 4096;
   localparam int FILL_BUFFER_BYTES = 64;
   localparam int MAX_ADDRESS_BYTES = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam int IDX_W       = $clog2(MAX_CHUNKS);
   localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEPS   = 33;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_ERASE = 2'd2;
   localparam logic [1:0] CMD_BAD   = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_RANGE       = 3'd2;
   localparam logic [2:0] ST_MISALIGNED  = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ST_TOO_MANY    = 3'd5;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_FILL  = 2'd2;

   localparam logic [2:0] CSR_MEMORY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_BASE_OFFSET   = 3'd1;
   localparam logic [2:0] CSR_ADDRESS_BYTES = 3'd2;
   localparam logic [2:0] CSR_READ_BLOCK    = 3'd3;
   localparam logic [2:0] CSR_PAGE_SIZE     = 3'd4;
   localparam logic [2:0] CSR_WRITE_ALIGN   = 3'd5;
   localparam logic [2:0] CSR_WRITE_GRANULE = 3'd6;
   localparam logic [2:0] CSR_ERASE_SIZE    = 3'd7;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] first_addr;
      logic [12:0] num_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  transfer_kind;
      logic [31:0] device_address;
      logic [11:0] buffer_offset;
      logic [12:0] transfer_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [32:0] memory_size;
      logic [31:0] base_offset;
      logic [2:0]  address_bytes;
      logic [12:0] read_block;
      logic [12:0] page_size;
      logic [12:0] write_align;
      logic [12:0] write_granule;
      logic [12:0] erase_size;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      memory_size:   33'd65536,
      base_offset:   32'd0,
      address_bytes: 3'd2,
      read_block:    13'd0,
      page_size:     13'd64,
      write_align:   13'd0,
      write_granule: 13'd0,
      erase_size:    13'd0
   };

   // request after front-end screening; status is ST_OK or the early error
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] first_addr;
      logic [12:0] num_bytes;
      logic [2:0]  status;
   } desc_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [11:0] off;
      logic [12:0] len;
   } xfer_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ_CHK,
      BK_READ_LOOP,
      BK_WR_CHK,
      BK_WR_ALIGN,
      BK_WR_GRAN,
      BK_WR_PAGE,
      BK_WR_LOOP,
      BK_ER_BLOCK,
      BK_ER_PIECE,
      BK_ER_TRIM,
      BK_ER_NEXT,
      BK_FINISH,
      BK_PRIME,
      BK_OUT,
      BK_STAT
   } back_state_type;

endpackage

>>> rtl/etcs_front.sv
// Front end: screens an incoming request for command, address width and length errors.
// Depends on etcs_pkg.
module etcs_front (
   input  etcs_pkg::req_type  req,
   input  etcs_pkg::cfg_type  cfg,
   output etcs_pkg::desc_type desc
);
   import etcs_pkg::*;

   always_comb begin
      desc.command    = req.command;
      desc.first_addr = req.first_addr;
      desc.num_bytes  = req.num_bytes;
      desc.status     = ST_OK;
      if (req.command == CMD_BAD || cfg.address_bytes == 3'd0 ||
          cfg.address_bytes > 3'(MAX_ADDRESS_BYTES)) begin
         desc.status = ST_INVALID;
      end else if (req.command != CMD_ERASE && req.num_bytes > 13'(MAX_LENGTH)) begin
         desc.status = ST_INVALID;
      end
   end

endmodule

>>> rtl/etcs_queue.sv
// Short request queue between the front end and the transfer generator.
// Depends on etcs_pkg.
module etcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  etcs_pkg::desc_type push_data,
   input  logic               pop,
   output logic               valid,
   output etcs_pkg::desc_type data
);
   import etcs_pkg::*;

   desc_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign valid   = (count_ff != '0);
   assign data    = slot_ff[rd_ptr_ff];
   assign do_push = push && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/etcs_div.sv
// Bit-serial remainder unit: 33-bit dividend by 13-bit divisor, one bit per cycle.
// Depends on etcs_pkg. Divisor must stay stable while a run is in progress.
module etcs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [32:0] dividend,
   input  logic [12:0] divisor,
   output logic        done,
   output logic [12:0] remainder
);
   import etcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0]          dvd_ff, dvd_in;
   logic [12:0]          rem_ff, rem_in;
   logic [13:0]          trial;

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign trial     = {rem_ff, dvd_ff[32]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[31:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 13'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[12:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

endmodule

>>> rtl/etcs_back.sv
// Back end: walks one screened request, builds its transfer list in a local memory,
// then plays the list out one word per cycle. Depends on etcs_pkg and etcs_div.
module etcs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  etcs_pkg::desc_type q_data,
   output logic               q_pop,
   input  etcs_pkg::cfg_type  cfg,
   output logic               busy,
   output logic               rsp_strobe,
   output etcs_pkg::rsp_type  rsp_word
);
   import etcs_pkg::*;

   back_state_type   state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [2:0]       st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [32:0]      ws_ff, ws_in;
   logic [12:0]      wl_ff, wl_in;
   logic [1:0]       wkind_ff, wkind_in;
   logic [11:0]      woff_ff, woff_in;
   logic [12:0]      pos_ff, pos_in;
   logic [12:0]      pgoff_ff, pgoff_in;
   logic [32:0]      blk_ff, blk_in;
   logic [12:0]      epos_ff, epos_in;
   logic [12:0]      echunk_ff, echunk_in;
   logic             div_go_ff, div_go_in;
   logic [32:0]      div_a_ff, div_a_in;
   logic [12:0]      div_b_ff, div_b_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   xfer_type         mem [MAX_CHUNKS];
   xfer_type         mem_q_ff;
   xfer_type         mem_wd;
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;

   logic             div_done;
   logic [12:0]      div_rem;

   logic [32:0]      cur;
   logic [33:0]      abs_addr;
   logic             fits;
   logic             win_ok;
   logic [12:0]      rem_len;
   logic [12:0]      rchunk;
   logic [12:0]      to_end;
   logic [12:0]      wchunk;
   logic [12:0]      left;
   logic [12:0]      chunk0;
   logic [12:0]      trimmed;
   logic [CNT_W-1:0] idx_next;
   logic             list_full;

   function automatic logic addr_fits(input logic [33:0] a, input logic [2:0] nb);
      logic ok;
      case (nb)
         3'd1:    ok = (a[33:8] == '0);
         3'd2:    ok = (a[33:16] == '0);
         3'd3:    ok = (a[33:24] == '0);
         3'd4:    ok = (a[33:32] == '0);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   etcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign busy       = (state_ff != BK_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   assign cur       = ws_ff + {20'd0, pos_ff};
   assign abs_addr  = {1'b0, cur} + {2'd0, cfg.base_offset};
   assign fits      = addr_fits(abs_addr, cfg.address_bytes);
   assign win_ok    = (wl_ff == '0) ||
                      ((ws_ff < cfg.memory_size) &&
                       ({20'd0, wl_ff} <= cfg.memory_size - ws_ff));
   assign rem_len   = wl_ff - pos_ff;
   assign rchunk    = (cfg.read_block != '0 && cfg.read_block < rem_len) ?
                      cfg.read_block : rem_len;
   assign to_end    = cfg.page_size - pgoff_ff;
   assign wchunk    = (cfg.page_size != '0 && to_end < rem_len) ? to_end : rem_len;
   assign left      = cfg.erase_size - epos_ff;
   assign chunk0    = (left > 13'(FILL_BUFFER_BYTES)) ? 13'(FILL_BUFFER_BYTES) : left;
   assign trimmed   = (cfg.write_granule > 13'd1) ? echunk_ff - div_rem : echunk_ff;
   assign idx_next  = idx_ff + 1'b1;
   assign list_full = (cnt_ff == CNT_W'(MAX_CHUNKS));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      ws_in         = ws_ff;
      wl_in         = wl_ff;
      wkind_in      = wkind_ff;
      woff_in       = woff_ff;
      pos_in        = pos_ff;
      pgoff_in      = pgoff_ff;
      blk_in        = blk_ff;
      epos_in       = epos_ff;
      echunk_in     = echunk_ff;
      div_go_in     = 1'b0;
      div_a_in      = div_a_ff;
      div_b_in      = div_b_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_wd        = '0;
      rd_addr       = '0;
      q_pop         = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_data.command;
               cnt_in = '0;
               idx_in = '0;
               pos_in = '0;
               if (q_data.status != ST_OK) begin
                  st_in    = q_data.status;
                  state_in = BK_FINISH;
               end else if (q_data.command == CMD_READ) begin
                  ws_in    = {1'b0, q_data.first_addr};
                  wl_in    = q_data.num_bytes;
                  state_in = BK_READ_CHK;
               end else if (q_data.command == CMD_WRITE) begin
                  // an empty write is checked at address zero
                  ws_in    = (q_data.num_bytes == '0) ? '0 : {1'b0, q_data.first_addr};
                  wl_in    = q_data.num_bytes;
                  wkind_in = KIND_WRITE;
                  woff_in  = '0;
                  state_in = BK_WR_CHK;
               end else if (cfg.erase_size == '0) begin
                  st_in    = ST_UNSUPPORTED;
                  state_in = BK_FINISH;
               end else begin
                  blk_in    = {1'b0, q_data.first_addr};
                  div_go_in = 1'b1;
                  div_a_in  = {1'b0, q_data.first_addr};
                  div_b_in  = cfg.erase_size;
                  state_in  = BK_ER_BLOCK;
               end
            end
         end
         BK_READ_CHK: begin
            if (!win_ok) begin
               st_in    = ST_RANGE;
               state_in = BK_FINISH;
            end else begin
               state_in = BK_READ_LOOP;
            end
         end
         BK_READ_LOOP: begin
            if (pos_ff == wl_ff) begin
               st_in    = ST_OK;
               state_in = BK_FINISH;
            end else if (!fits) begin
               st_in    = ST_RANGE;
               state_in = BK_FINISH;
            end else if (list_full) begin
               st_in    = ST_TOO_MANY;
               state_in = BK_FINISH;
            end else begin
               mem_we      = 1'b1;
               mem_wd.kind = KIND_READ;
               mem_wd.addr = abs_addr[31:0];
               mem_wd.off  = pos_ff[11:0];
               mem_wd.len  = rchunk;
               cnt_in      = cnt_ff + 1'b1;
               pos_in      = pos_ff + rchunk;
            end
         end
         BK_WR_CHK: begin
            pos_in = '0;
            if (!win_ok) begin
               st_in    = ST_RANGE;
               state_in = BK_FINISH;
            end else begin
               div_go_in = 1'b1;
               div_a_in  = ws_ff;
               div_b_in  = cfg.write_align;
               state_in  = BK_WR_ALIGN;
            end
         end
         BK_WR_ALIGN: begin
            if (div_done) begin
               if (cfg.write_align != '0 && div_rem != '0) begin
                  st_in    = ST_MISALIGNED;
                  state_in = BK_FINISH;
               end else begin
                  div_go_in = 1'b1;
                  div_a_in  = {20'd0, wl_ff};
                  div_b_in  = cfg.write_granule;
                  state_in  = BK_WR_GRAN;
               end
            end
         end
         BK_WR_GRAN: begin
            if (div_done) begin
               if (cfg.write_granule != '0 && div_rem != '0) begin
                  st_in    = ST_INVALID;
                  state_in = BK_FINISH;
               end else begin
                  div_go_in = 1'b1;
                  div_a_in  = ws_ff;
                  div_b_in  = cfg.page_size;
                  state_in  = BK_WR_PAGE;
               end
            end
         end
         BK_WR_PAGE: begin
            if (div_done) begin
               pgoff_in = (cfg.page_size != '0) ? div_rem : '0;
               state_in = BK_WR_LOOP;
            end
         end
         BK_WR_LOOP: begin
            if (pos_ff == wl_ff) begin
               if (cmd_ff == CMD_ERASE) begin
                  state_in = BK_ER_NEXT;
               end else begin
                  st_in    = ST_OK;
                  state_in = BK_FINISH;
               end
            end else if (!fits) begin
               st_in    = ST_RANGE;
               state_in = BK_FINISH;
            end else if (list_full) begin
               st_in    = ST_TOO_MANY;
               state_in = BK_FINISH;
            end else begin
               mem_we      = 1'b1;
               mem_wd.kind = wkind_ff;
               mem_wd.addr = abs_addr[31:0];
               mem_wd.off  = woff_ff + pos_ff[11:0];
               mem_wd.len  = wchunk;
               cnt_in      = cnt_ff + 1'b1;
               pos_in      = pos_ff + wchunk;
               // either the piece ends here or the next one starts on a page boundary
               pgoff_in    = '0;
            end
         end
         BK_ER_BLOCK: begin
            if (div_done) begin
               blk_in   = blk_ff - {20'd0, div_rem};
               epos_in  = '0;
               state_in = BK_ER_PIECE;
            end
         end
         BK_ER_PIECE: begin
            echunk_in = chunk0;
            div_go_in = 1'b1;
            div_a_in  = {20'd0, chunk0};
            div_b_in  = cfg.write_granule;
            state_in  = BK_ER_TRIM;
         end
         BK_ER_TRIM: begin
            if (div_done) begin
               if (trimmed == '0) begin
                  st_in    = ST_INVALID;
                  state_in = BK_FINISH;
               end else begin
                  echunk_in = trimmed;
                  ws_in     = blk_ff + {20'd0, epos_ff};
                  wl_in     = trimmed;
                  wkind_in  = KIND_FILL;
                  woff_in   = epos_ff[11:0];
                  state_in  = BK_WR_CHK;
               end
            end
         end
         BK_ER_NEXT: begin
            epos_in = epos_ff + echunk_ff;
            if (epos_ff + echunk_ff >= cfg.erase_size) begin
               st_in    = ST_OK;
               state_in = BK_FINISH;
            end else begin
               state_in = BK_ER_PIECE;
            end
         end
         BK_FINISH: begin
            if (st_ff == ST_TOO_MANY || (st_ff != ST_OK && list_full)) begin
               st_in    = ST_TOO_MANY;
               state_in = BK_STAT;
            end else if (cnt_ff == '0) begin
               state_in = BK_STAT;
            end else begin
               idx_in   = '0;
               state_in = BK_PRIME;
            end
         end
         BK_PRIME: begin
            rd_addr  = '0;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            rd_addr                = idx_next[IDX_W-1:0];
            rsp_strobe_in          = 1'b1;
            rsp_in.status          = ST_OK;
            rsp_in.transfer_kind   = mem_q_ff.kind;
            rsp_in.device_address  = mem_q_ff.addr;
            rsp_in.buffer_offset   = mem_q_ff.off;
            rsp_in.transfer_length = mem_q_ff.len;
            rsp_in.last            = (st_ff == ST_OK) && (idx_next == cnt_ff);
            idx_in                 = idx_next;
            if (idx_next == cnt_ff) begin
               state_in = (st_ff != ST_OK) ? BK_STAT : BK_IDLE;
            end
         end
         BK_STAT: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = st_ff;
            rsp_in.last   = 1'b1;
            state_in      = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         div_go_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         div_go_ff     <= div_go_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      st_ff     <= st_in;
      ws_ff     <= ws_in;
      wl_ff     <= wl_in;
      wkind_ff  <= wkind_in;
      woff_ff   <= woff_in;
      pos_ff    <= pos_in;
      pgoff_ff  <= pgoff_in;
      blk_ff    <= blk_in;
      epos_ff   <= epos_in;
      echunk_ff <= echunk_in;
      div_a_ff  <= div_a_in;
      div_b_ff  <= div_b_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= mem_wd;
      end
      mem_q_ff <= mem[rd_addr];
   end

endmodule

>>> rtl/eeprom_transfer_chunk_splitter.sv
// Top level of the EEPROM transfer splitter: register file, front end, queue, back end.
// Depends on etcs_pkg, etcs_front, etcs_queue, etcs_back (which holds etcs_div).
//
// Usage:
//   Request: drive req_word and raise start; the word is taken at an edge where
//   start is high and busy is low. busy stays high until the request's list is out.
//   Results: one word per rsp_strobe cycle, must be taken in that cycle; last marks
//   the final word of a request. Transfers follow each other on back-to-back cycles.
//   Config: csr_wr_en/csr_index/csr_wdata write one register per cycle, only while
//   busy is low and no results are pending.
// Operation:
//   One request at a time. Building the list writes each transfer into a local memory;
//   every remainder (write alignment, length unit and page offset for each write or
//   erase piece, block base and trim for erase) runs on the shared bit-serial
//   remainder unit. Playback then sends the result words on back-to-back cycles.
// Reset: synchronous; clears the queue, the state machines and the registers to
//   their power-on values. No clearing pass is needed.
module eeprom_transfer_chunk_splitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  etcs_pkg::req_type req_word,
   output logic              rsp_strobe,
   output etcs_pkg::rsp_type rsp_word,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [32:0]       csr_wdata
);
   import etcs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc;
   desc_type q_data;
   logic     q_valid;
   logic     q_pop;
   logic     back_busy;
   logic     accept;

   assign busy   = q_valid || back_busy;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MEMORY_SIZE:   cfg_in.memory_size   = csr_wdata;
            CSR_BASE_OFFSET:   cfg_in.base_offset   = csr_wdata[31:0];
            CSR_ADDRESS_BYTES: cfg_in.address_bytes = csr_wdata[2:0];
            CSR_READ_BLOCK:    cfg_in.read_block    = csr_wdata[12:0];
            CSR_PAGE_SIZE:     cfg_in.page_size     = csr_wdata[12:0];
            CSR_WRITE_ALIGN:   cfg_in.write_align   = csr_wdata[12:0];
            CSR_WRITE_GRANULE: cfg_in.write_granule = csr_wdata[12:0];
            CSR_ERASE_SIZE:    cfg_in.erase_size    = csr_wdata[12:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   etcs_front u_front (
      .req  (req_word),
      .cfg  (cfg_ff),
      .desc (front_desc)
   );

   etcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_desc),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_data)
   );

   etcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .cfg        (cfg_ff),
      .busy       (back_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

>>> rtl/etcs_checker.sv
// Port-level checks for the EEPROM transfer splitter, bound to the top level.
// Depends on etcs_pkg.
module etcs_props (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input etcs_pkg::rsp_type rsp_word
);
   import etcs_pkg::*;

   // a taken request keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after a request was taken");

   // error and status-only words always close the request
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status != ST_OK |-> rsp_word.last)
      else $error("error word not marked last");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.transfer_length == '0 |-> rsp_word.last)
      else $error("zero-length word not marked last");

   // a request's words come out without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last |=> rsp_strobe)
      else $error("gap inside a result list");

endmodule

bind eeprom_transfer_chunk_splitter etcs_props u_etcs_props (.*);
